// ===== rtl/aligned_bump_suballocator_unit_assert.svh =====
// Assertion macros used by the allocator back end
`ifndef ALIGNED_BUMP_SUBALLOCATOR_UNIT_ASSERT_SVH
`define ALIGNED_BUMP_SUBALLOCATOR_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define ABS_ASSERT_IMP(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define ABS_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/absa_pkg.sv =====
`default_nettype none
package absa_pkg;

  localparam int unsigned MaxSlotsDef     = 16;
  localparam int unsigned RingSectionsDef = 3;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_EOF     = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_SLOT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_VMAX    = 3'd0,
    CFG_IMAX    = 3'd1,
    CFG_UMAX    = 3'd2,
    CFG_VALIGN  = 3'd3,
    CFG_IALIGN  = 3'd4,
    CFG_UALIGN  = 3'd5,
    CFG_PERSIST = 3'd6,
    CFG_SPARE   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MOD_REQ,
    B_SCAN,
    B_SCAN_MUL,
    B_SCAN_MOD,
    B_SCAN_CHK,
    B_NEW_MUL,
    B_NEW_MOD,
    B_NEW_CHK,
    B_SWEEP,
    B_SWEEP_MUL,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  buffer_kind;
    logic [23:0] request_bytes;
    logic [15:0] request_align;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [25:0] grant_offset;
    logic [23:0] grant_bytes;
    logic        slot_created;
  } out_item_t;

  // Classified work handed from front to back
  typedef struct packed {
    op_e         op;
    logic        reject;
    status_e     rej_status;
    logic [1:0]  kind;
    logic [23:0] bytes;
    logic [15:0] req_align;
    logic [8:0]  base_align;
    logic [23:0] cap;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/absa_front.sv =====
`default_nettype none
module absa_front
  import absa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire in_item_t  item_i,
  input  wire logic      valid_i,
  output logic           ready_o,
  output cmd_t           cmd_o,
  output logic           cmd_valid_o,
  input  wire logic      cmd_ready_i,
  output logic           persist_o
);

  logic [23:0] max_q [3];
  logic [8:0]  align_q [3];
  logic        persist_q;
  logic [1:0]  k;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q[0] <= 24'd65536;
      max_q[1] <= 24'd65536;
      max_q[2] <= 24'd65536;
      align_q[0] <= 9'd4;
      align_q[1] <= 9'd2;
      align_q[2] <= 9'd256;
      persist_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_VMAX:    max_q[0] <= cfg_wdata_i;
        CFG_IMAX:    max_q[1] <= cfg_wdata_i;
        CFG_UMAX:    max_q[2] <= cfg_wdata_i;
        CFG_VALIGN:  align_q[0] <= cfg_wdata_i[8:0];
        CFG_IALIGN:  align_q[1] <= cfg_wdata_i[8:0];
        CFG_UALIGN:  align_q[2] <= cfg_wdata_i[8:0];
        CFG_PERSIST: persist_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign persist_o   = persist_q;
  assign ready_o     = cmd_ready_i;
  assign cmd_valid_o = valid_i;
  assign k           = (item_i.buffer_kind == 2'd3) ? 2'd0 : item_i.buffer_kind;

  // Classify the item
  always_comb begin
    cmd_o.op         = op_e'(item_i.operation);
    cmd_o.kind       = item_i.buffer_kind;
    cmd_o.bytes      = item_i.request_bytes;
    cmd_o.req_align  = item_i.request_align;
    cmd_o.cap        = max_q[k];
    cmd_o.base_align = (align_q[k] == 9'd0) ? 9'd1 : align_q[k];
    cmd_o.reject     = 1'b0;
    cmd_o.rej_status = ST_OK;
    if (item_i.operation == OP_ACQUIRE) begin
      if (item_i.buffer_kind == 2'd3) begin
        cmd_o.reject = 1'b1;
        cmd_o.rej_status = ST_NO_SLOT;
      end else if (item_i.request_bytes > max_q[k]) begin
        cmd_o.reject = 1'b1;
        cmd_o.rej_status = ST_TOO_BIG;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/absa_queue.sv =====
`default_nettype none
module absa_queue
  import absa_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t wr_data_i,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  output cmd_t      rd_data_o,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // Store the item
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Advance the pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/absa_mod.sv =====
`default_nettype none
// Restoring remainder a % b, one quotient bit a cycle
module absa_mod (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [25:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic [15:0]      rem_o
);

  logic [25:0] n_q;
  logic [15:0] d_q;
  logic [16:0] r_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [16:0] sh;

  assign sh = {r_q[15:0], n_q[25]};
  assign rem_o = r_q[15:0];

  // Shift in one numerator bit and subtract where it fits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      r_q    <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd26;
        r_q    <= '0;
      end else if (busy_q) begin
        r_q <= (sh >= {1'b0, d_q}) ? sh - {1'b0, d_q} : sh;
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
    end else if (busy_q) begin
      n_q <= {n_q[24:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/absa_back.sv =====
`default_nettype none
module absa_back
  import absa_pkg::*;
#(
  parameter int unsigned MaxSlots     = MaxSlotsDef,
  parameter int unsigned RingSections = RingSectionsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  wire logic  persist_i,
  output out_item_t  item_o,
  output logic       valid_o,
  input  wire logic  ready_i
);

  `include "aligned_bump_suballocator_unit_assert.svh"

  localparam int unsigned SW = $clog2(MaxSlots);
  localparam int unsigned RW = $clog2(RingSections);

  logic [MaxSlots-1:0] vld_q;
  logic [1:0]  kind_q [MaxSlots];
  logic [23:0] cap_q  [MaxSlots];
  logic [23:0] free_q [MaxSlots];
  logic [25:0] sbase_q[MaxSlots];
  logic [RW-1:0] ring_q;

  back_state_e st_q, st_d;
  cmd_t        c_q;
  logic [15:0] al_q;
  logic [SW:0] i_q;
  logic [SW-1:0] ix;
  logic [25:0] off_q;
  logic [47:0] prod_q;
  out_item_t   res_q;
  logic        res_v_q;

  logic        mstart;
  logic [25:0] mnum;
  logic [15:0] mden;
  logic        mdone;
  logic [15:0] mrem;
  logic [15:0] pad;
  logic [24:0] need;
  logic [SW:0] free_slot;
  logic        have_free;

  assign ix = i_q[SW-1:0];
  assign pad = (mrem == 16'd0) ? 16'd0 : al_q - mrem;
  assign need = {1'b0, c_q.bytes} + 25'(pad);

  absa_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mstart),
    .num_i  (mnum),
    .den_i  (mden),
    .done_o (mdone),
    .rem_o  (mrem)
  );

  // Find the lowest unused slot
  always_comb begin
    free_slot = '0;
    have_free = 1'b0;
    for (int j = MaxSlots - 1; j >= 0; j--) begin
      if (!vld_q[j]) begin
        free_slot = (SW+1)'(j);
        have_free = 1'b1;
      end
    end
  end

  assign cmd_ready_o = (st_q == B_IDLE) && !res_v_q;
  assign valid_o = res_v_q;
  assign item_o  = res_q;

  // Sequence next state
  always_comb begin
    st_d   = st_q;
    mstart = 1'b0;
    mnum   = {10'd0, c_q.req_align};
    mden   = {7'd0, c_q.base_align};
    unique case (st_q)
      B_IDLE: if (cmd_valid_i && cmd_ready_o) begin
        if (cmd_i.op == OP_ACQUIRE && !cmd_i.reject) begin
          st_d = B_MOD_REQ;
          mstart = 1'b1;
          mnum = {10'd0, cmd_i.req_align};
          mden = {7'd0, cmd_i.base_align};
        end else if (cmd_i.op == OP_EOF || cmd_i.op == OP_ADVANCE) begin
          st_d = B_SWEEP;
        end else begin
          st_d = B_OUT;
        end
      end
      B_MOD_REQ: if (mdone) st_d = B_SCAN;
      B_SCAN: begin
        if (i_q == (SW+1)'(MaxSlots)) st_d = B_NEW_MUL;
        else if (vld_q[ix] && kind_q[ix] == c_q.kind) begin
          st_d = B_SCAN_MOD;
          mstart = 1'b1;
          mnum = sbase_q[ix] + 26'(cap_q[ix] - free_q[ix]);
          mden = al_q;
        end
      end
      B_SCAN_MUL: st_d = B_SCAN;
      B_SCAN_MOD: if (mdone) st_d = B_SCAN_CHK;
      B_SCAN_CHK: st_d = ({1'b0, free_q[ix]} >= need) ? B_OUT : B_SCAN;
      B_NEW_MUL: begin
        if (!have_free) st_d = B_OUT;
        else begin
          st_d = B_NEW_MOD;
          mstart = 1'b1;
          mnum = persist_i ? prod_q[25:0] : 26'd0;
          mden = al_q;
        end
      end
      B_NEW_MOD: if (mdone) st_d = B_NEW_CHK;
      B_NEW_CHK: st_d = B_OUT;
      B_SWEEP: begin
        if (i_q == (SW+1)'(MaxSlots) || c_q.op == OP_EOF) st_d = B_OUT;
        else st_d = B_SWEEP_MUL;
      end
      B_SWEEP_MUL: st_d = B_SWEEP;
      B_OUT: st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= B_IDLE;
    else st_q <= st_d;
  end

  // Work the slot table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= MaxSlots'(3'b111);
      ring_q  <= '0;
      res_v_q <= 1'b0;
      i_q     <= '0;
      for (int j = 0; j < MaxSlots; j++) begin
        kind_q[j]  <= (j < 3) ? 2'(j) : 2'd0;
        cap_q[j]   <= (j < 3) ? 24'd65536 : 24'd0;
        free_q[j]  <= (j < 3) ? 24'd65536 : 24'd0;
        sbase_q[j] <= '0;
      end
    end else begin
      if (res_v_q && ready_i) res_v_q <= 1'b0;
      unique case (st_q)
        B_IDLE: if (cmd_valid_i && cmd_ready_o) begin
          c_q <= cmd_i;
          i_q <= '0;
          res_q <= '{status: cmd_i.reject ? cmd_i.rej_status : ST_OK,
                     slot_index: 4'd0, grant_offset: 26'd0, grant_bytes: 24'd0,
                     slot_created: 1'b0};
          if (cmd_i.op == OP_ADVANCE && persist_i)
            ring_q <= (ring_q == RW'(RingSections - 1)) ? '0 : ring_q + 1'b1;
        end
        B_MOD_REQ: if (mdone)
          al_q <= (c_q.req_align != 16'd0 && mrem == 16'd0)
                  ? c_q.req_align : {7'd0, c_q.base_align};
        B_SCAN: begin
          if (i_q == (SW+1)'(MaxSlots)) prod_q <= 48'(ring_q) * 48'(c_q.cap);
          else if (vld_q[ix] && kind_q[ix] == c_q.kind)
            off_q <= sbase_q[ix] + 26'(cap_q[ix] - free_q[ix]);
          else i_q <= i_q + 1'b1;
        end
        B_SCAN_CHK: begin
          if ({1'b0, free_q[ix]} >= need) begin
            free_q[ix] <= free_q[ix] - need[23:0];
            res_q <= '{status: ST_OK, slot_index: 4'(ix),
                       grant_offset: off_q + 26'(pad), grant_bytes: c_q.bytes,
                       slot_created: 1'b0};
          end else i_q <= i_q + 1'b1;
        end
        B_NEW_MUL: begin
          if (!have_free) res_q.status <= ST_NO_SLOT;
          else begin
            i_q <= free_slot;
            off_q <= persist_i ? prod_q[25:0] : 26'd0;
          end
        end
        B_NEW_CHK: begin
          vld_q[ix]   <= 1'b1;
          kind_q[ix]  <= c_q.kind;
          cap_q[ix]   <= c_q.cap;
          sbase_q[ix] <= off_q;
          free_q[ix]  <= (need > {1'b0, c_q.cap}) ? 24'd0 : c_q.cap - need[23:0];
          res_q <= '{status: (need > {1'b0, c_q.cap}) ? ST_OVERFLOW : ST_OK,
                     slot_index: 4'(ix), grant_offset: off_q + 26'(pad),
                     grant_bytes: c_q.bytes, slot_created: 1'b1};
        end
        B_SWEEP: begin
          if (c_q.op == OP_EOF) begin
            if (!persist_i)
              for (int j = 0; j < MaxSlots; j++)
                if (vld_q[j]) free_q[j] <= cap_q[j];
          end else if (i_q != (SW+1)'(MaxSlots)) begin
            prod_q <= 48'(ring_q) * 48'(cap_q[ix]);
          end
        end
        B_SWEEP_MUL: begin
          if (persist_i && vld_q[ix]) begin
            sbase_q[ix] <= prod_q[25:0];
            free_q[ix]  <= cap_q[ix];
          end
          i_q <= i_q + 1'b1;
        end
        B_OUT: res_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  `ABS_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, st_q != B_IDLE, !cmd_ready_o)
  `ABS_ASSERT_NEXT(a_out_raises, clk_i, rst_ni, st_q == B_OUT, valid_o)
  `ABS_ASSERT_IMP(a_new_slot_ok, clk_i, rst_ni,
                  valid_o && item_o.slot_created, vld_q[item_o.slot_index[SW-1:0]])

endmodule
`default_nettype wire

// ===== rtl/aligned_bump_suballocator_unit.sv =====
// Aligned bump sub-allocator over a table of buffer slots.
// Input channel in_valid_i/in_ready_o carries an item: operation, kind,
// byte count and wanted alignment. Output channel out_valid_o/out_ready_i
// returns one result item per input item, in order.
// Configuration: cfg_we_i with cfg_idx_i and cfg_wdata_i, written at once.
// The front classifies items (size check, kind check, base alignment) and
// places them in a two-entry queue; the back walks the slot table.
// Steps: a remainder-unit pass for the alignment check, then per matching
// slot a pass of the remainder unit (26-bit restoring modulo,
// one bit per cycle), plus a scan step per slot skipped; end of frame
// is one sweep, advance visits each slot. Items are worked one at a time.
// Reset: slots 0, 1, 2 hold vertex, index and uniform with 65536 bytes.
// A stalled receiver holds the result; the back waits, and the queue
// keeps taking up to two further items.
`default_nettype none
module aligned_bump_suballocator_unit
  import absa_pkg::*;
#(
  parameter int unsigned MaxSlots     = MaxSlotsDef,
  parameter int unsigned RingSections = RingSectionsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire in_item_t    in_item_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output out_item_t        out_item_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i
);

  cmd_t fq_cmd, bq_cmd;
  logic fq_v, fq_r, bq_v, bq_r, persist;

  absa_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i), .item_i(in_item_i), .valid_i(in_valid_i),
    .ready_o(in_ready_o), .cmd_o(fq_cmd), .cmd_valid_o(fq_v),
    .cmd_ready_i(fq_r), .persist_o(persist)
  );

  absa_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .wr_data_i(fq_cmd), .wr_valid_i(fq_v),
    .wr_ready_o(fq_r), .rd_data_o(bq_cmd), .rd_valid_o(bq_v), .rd_ready_i(bq_r)
  );

  absa_back #(.MaxSlots(MaxSlots), .RingSections(RingSections)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(bq_cmd), .cmd_valid_i(bq_v),
    .cmd_ready_o(bq_r), .persist_i(persist), .item_o(out_item_o),
    .valid_o(out_valid_o), .ready_i(out_ready_i)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import absa_pkg::*;

  localparam int unsigned SlotCount = 16;
  localparam int unsigned SectionCount = 3;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [23:0] cfg_wdata_i = '0;
  in_item_t in_item_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  out_item_t out_item_o;
  logic out_valid_o;
  logic out_ready_i = 1'b0;

  aligned_bump_suballocator_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .in_item_i(in_item_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .out_item_o(out_item_o), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Allocator state as predicted
  logic [23:0] max_bytes [3];
  logic [8:0] base_align [3];
  logic persist;
  logic slot_used [SlotCount];
  logic [1:0] slot_type [SlotCount];
  logic [23:0] slot_cap [SlotCount];
  logic [23:0] slot_left [SlotCount];
  logic [25:0] slot_base [SlotCount];
  int unsigned section;

  out_item_t grant_queue [$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_stall = 1'b0;

  task automatic reset_allocator();
    max_bytes = '{24'd65536, 24'd65536, 24'd65536};
    base_align = '{9'd4, 9'd2, 9'd256};
    persist = 1'b0;
    section = 0;
    for (int i = 0; i < SlotCount; i++) begin
      slot_used[i] = (i < 3);
      slot_type[i] = (i < 3) ? i[1:0] : 2'd0;
      slot_cap[i] = (i < 3) ? 24'd65536 : 24'd0;
      slot_left[i] = slot_cap[i];
      slot_base[i] = '0;
    end
  endtask

  function automatic longint unsigned pad_to(longint unsigned off, longint unsigned al);
    return (al - off % al) % al;
  endfunction

  // Compute the grant for one item and update the slot table
  function automatic out_item_t allocate(in_item_t it);
    out_item_t r;
    longint unsigned al, off, pad, need;
    int unsigned k;
    r = '0;
    k = it.buffer_kind;
    if (it.operation == OP_EOF) begin
      if (!persist)
        for (int i = 0; i < SlotCount; i++)
          if (slot_used[i]) slot_left[i] = slot_cap[i];
      return r;
    end
    if (it.operation == OP_ADVANCE) begin
      if (persist) begin
        section = (section + 1) % SectionCount;
        for (int i = 0; i < SlotCount; i++)
          if (slot_used[i]) begin
            slot_base[i] = 26'(longint'(section) * slot_cap[i]);
            slot_left[i] = slot_cap[i];
          end
      end
      return r;
    end
    if (it.operation != OP_ACQUIRE) return r;
    if (k > 2) begin
      r.status = ST_NO_SLOT;
      return r;
    end
    if (it.request_bytes > max_bytes[k]) begin
      r.status = ST_TOO_BIG;
      return r;
    end
    al = (base_align[k] == 0) ? 1 : base_align[k];
    if (it.request_align != 0 && it.request_align % al == 0) al = it.request_align;
    for (int i = 0; i < SlotCount; i++)
      if (slot_used[i] && slot_type[i] == k) begin
        off = longint'(slot_base[i]) + (slot_cap[i] - slot_left[i]);
        pad = pad_to(off, al);
        if (longint'(slot_left[i]) >= it.request_bytes + pad) begin
          slot_left[i] = slot_left[i] - 24'(it.request_bytes + pad);
          r.slot_index = i[3:0];
          r.grant_offset = 26'(off + pad);
          r.grant_bytes = it.request_bytes;
          return r;
        end
      end
    for (int i = 0; i < SlotCount; i++)
      if (!slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_type[i] = k[1:0];
        slot_cap[i] = max_bytes[k];
        slot_base[i] = persist ? 26'(longint'(section) * max_bytes[k]) : 26'd0;
        off = slot_base[i];
        pad = pad_to(off, al);
        need = it.request_bytes + pad;
        r.slot_index = i[3:0];
        r.grant_offset = 26'(off + pad);
        r.grant_bytes = it.request_bytes;
        r.slot_created = 1'b1;
        if (need > slot_cap[i]) begin
          slot_left[i] = '0;
          r.status = ST_OVERFLOW;
        end else begin
          slot_left[i] = slot_cap[i] - 24'(need);
        end
        return r;
      end
    r.status = ST_NO_SLOT;
    return r;
  endfunction

  // Send one item, with a random gap before it; drop valid while idling
  task automatic send_item(in_item_t it);
    while (!no_stall && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    grant_queue.push_back(allocate(it));
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_VMAX, CFG_IMAX, CFG_UMAX: max_bytes[idx] = val;
      CFG_VALIGN, CFG_IALIGN, CFG_UALIGN: base_align[idx - 3] = val[8:0];
      CFG_PERSIST: persist = val[0];
      default: ;
    endcase
  endtask

  // Drain all grants, then let the back settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (grant_queue.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic in_item_t acquire(int k, int unsigned b, int unsigned a);
    in_item_t it;
    it.operation = OP_ACQUIRE;
    it.buffer_kind = k[1:0];
    it.request_bytes = b[23:0];
    it.request_align = a[15:0];
    return it;
  endfunction

  function automatic in_item_t control(op_e op);
    in_item_t it;
    it = '0;
    it.operation = op;
    return it;
  endfunction

  task automatic test_directed();
    send_item(acquire(0, 0, 0));
    send_item(acquire(0, 100, 3));
    send_item(acquire(0, 100, 64));
    send_item(acquire(1, 65536, 0));
    send_item(acquire(1, 1, 2));
    send_item(acquire(2, 65537, 0));
    send_item(acquire(2, 24'hFFFFFF, 16'hFFFF));
    send_item(acquire(3, 5, 0));
    send_item(acquire(2, 10, 512));
    send_item(control(OP_NONE));
    send_item(control(OP_ADVANCE));
    send_item(control(OP_EOF));
    send_item(acquire(0, 65536, 16'h8000));
    drain();
    write_reg(CFG_VALIGN, 24'd0);
    write_reg(CFG_VMAX, 24'd1);
    send_item(acquire(0, 1, 7));
    for (int i = 0; i < 14; i++) send_item(acquire(0, 1, 0));
    drain();
  endtask

  // Random items; outside extreme mode small capacities keep slot fill and overflow frequent
  task automatic test_random(int count, bit persistent, bit extreme);
    in_item_t it;
    int unsigned r;
    write_reg(CFG_PERSIST, persistent);
    for (int k = 0; k < 3; k++) begin
      write_reg(cfg_idx_e'(k), extreme ? 24'hFFFFFF : 24'($urandom_range(4096, 1)));
      write_reg(cfg_idx_e'(k + 3), extreme ? 24'd256 : 24'($urandom_range(256, 1)));
    end
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      it.operation = (r < 80) ? OP_ACQUIRE : (r < 88) ? OP_EOF : (r < 96) ? OP_ADVANCE : OP_NONE;
      it.buffer_kind = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      it.request_bytes = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(600));
      r = $urandom_range(3);
      it.request_align = (r == 0) ? 16'($urandom) : (r == 1) ? 16'd0 :
                         16'(base_align[it.buffer_kind == 3 ? 0 : it.buffer_kind] *
                             $urandom_range(4, 1));
      send_item(it);
    end
    drain();
  endtask

  // Receiver with random stalls unless no_stall is set
  always @(posedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(99) >= 21);
  end

  // Compare each result with the oldest grant
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grant_queue.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_item_o);
        errors++;
      end else begin
        want = grant_queue.pop_front();
        if (want.status != out_item_o.status)
          $display("%0t status exp %0d got %0d", $time, want.status, out_item_o.status);
        if (want.slot_index != out_item_o.slot_index)
          $display("%0t slot exp %0d got %0d", $time, want.slot_index,
                   out_item_o.slot_index);
        if (want.grant_offset != out_item_o.grant_offset)
          $display("%0t offset exp %0d got %0d", $time, want.grant_offset,
                   out_item_o.grant_offset);
        if (want.grant_bytes != out_item_o.grant_bytes)
          $display("%0t bytes exp %0d got %0d", $time, want.grant_bytes,
                   out_item_o.grant_bytes);
        if (want.slot_created != out_item_o.slot_created)
          $display("%0t created exp %0d got %0d", $time, want.slot_created,
                   out_item_o.slot_created);
        if (want != out_item_o) errors++;
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** aligned_bump_suballocator_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    reset_allocator();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 1'b0, 1'b0);
    test_random(300, 1'b1, 1'b0);
    no_stall = 1'b1;
    test_random(250, 1'b1, 1'b0);
    no_stall = 1'b0;
    test_random(250, 1'b0, 1'b1);
    test_random(250, 1'b1, 1'b1);
    if (errors == 0) $display("** aligned_bump_suballocator_unit: PASSED **");
    else $display("** aligned_bump_suballocator_unit: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
